@@ rtl/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

  // Result kinds carried on the output tuser field.
  typedef enum logic [1:0] {
    KIND_UNIT  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Most result beats that one input byte can cause.
  localparam int unsigned MaxResults = 3;

  localparam logic [15:0] SurrHiBase = 16'hD800;
  localparam logic [15:0] SurrLoBase = 16'hDC00;
  localparam logic [20:0] SuppBase   = 21'h10000;

  // One result beat.
  typedef struct packed {
    logic [15:0] code_unit;
    kind_e       kind;
    logic        last;
  } result_t;

  // All result beats caused by one input byte, first beat in entry zero.
  typedef struct packed {
    logic [1:0]                 count;
    result_t [MaxResults-1:0]   item;
  } result_set_t;

endpackage

@@ rtl/utf8_to_utf16_decoder.sv @@
// Top level of the UTF-8 to UTF-16 decoder.
// Bytes of UTF-8 text enter on the slave stream (tlast marks the final byte of
// a text) and UTF-16 code units leave on the master stream, with tuser giving
// the kind of each beat (code unit, clean end, or error) and tlast set on the
// end or error beat that closes the text. One byte is accepted per cycle while
// the output takes every beat and each byte yields at most one beat. A byte in
// the input register is decoded there and moves into the result register once
// that register is free or its last beat is leaving, which offers its first
// beat. A byte that yields two or three beats (a surrogate pair, a unit and
// the end beat, or a pair and the end beat) holds the result register until
// its last beat leaves; input stalls with the next byte in the input register.
module utf8_to_utf16_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // code_unit
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // last
);
  import u8u16_pkg::*;

  logic        set_valid;
  logic        set_ready;
  result_set_t set;

  u8u16_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .set_valid_o   (set_valid),
    .set_ready_i   (set_ready),
    .set_o         (set)
  );

  u8u16_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .set_valid_i   (set_valid),
    .set_ready_o   (set_ready),
    .set_i         (set),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ rtl/u8u16_decode.sv @@
// Input register, sequence state and per-byte decode into a result set.
module u8u16_decode (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // text_byte
  input  logic                  s_axis_tlast,   // end_of_text
  output logic                  set_valid_o,
  input  logic                  set_ready_i,
  output u8u16_pkg::result_set_t set_o
);
  import u8u16_pkg::*;

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        eot_q;
  logic [2:0]  expect_q, expect_d;
  logic [31:0] acc_q, acc_d;
  logic        skip_q, skip_d;
  logic        consume;

  result_set_t set_d;

  assign consume       = in_valid_q && set_ready_i;
  assign s_axis_tready = !in_valid_q || set_ready_i;
  assign set_valid_o   = in_valid_q;
  assign set_o         = set_d;

  // Input register: holds one byte while the result stage is busy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      byte_q <= s_axis_tdata;
      eot_q  <= s_axis_tlast;
    end
  end

  // Sequence state advances when the byte moves into the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q <= '0;
      acc_q    <= '0;
      skip_q   <= 1'b0;
    end else if (consume) begin
      expect_q <= expect_d;
      acc_q    <= acc_d;
      skip_q   <= skip_d;
    end
  end

  // Decode of the held byte against the open sequence.
  always_comb begin
    logic        err;
    logic        close;
    logic        is_cont;
    logic [1:0]  n;
    logic [31:0] v;
    logic [20:0] w;
    result_t     r;

    err      = 1'b0;
    close    = 1'b0;
    n        = '0;
    v        = '0;
    w        = '0;
    expect_d = expect_q;
    acc_d    = acc_q;
    skip_d   = skip_q;
    set_d    = '0;
    is_cont  = (byte_q[7:6] == 2'b10);
    r        = '0;

    if (skip_q) begin
      // Discard through the end of the text after an error.
      if (eot_q) begin
        skip_d = 1'b0;
      end
    end else begin
      if (expect_q != 3'd0) begin
        if (is_cont) begin
          acc_d    = {acc_q[25:0], byte_q[5:0]};
          expect_d = expect_q - 3'd1;
          close    = (expect_d == 3'd0) || eot_q;
        end else begin
          // A byte that breaks the sequence closes it and is dropped.
          close = 1'b1;
        end
      end else if (!byte_q[7]) begin
        r.code_unit = {8'h00, byte_q};
        r.kind      = KIND_UNIT;
        r.last      = 1'b0;
        set_d.item[n] = r;
        n = n + 2'd1;
      end else if (!byte_q[6]) begin
        err = 1'b1;
      end else begin
        // Lead byte: payload bits and number of continuation bytes.
        close = eot_q;
        if (!byte_q[5]) begin
          expect_d = 3'd1;
          acc_d    = {27'd0, byte_q[4:0]};
        end else if (!byte_q[4]) begin
          expect_d = 3'd2;
          acc_d    = {28'd0, byte_q[3:0]};
        end else if (!byte_q[3]) begin
          expect_d = 3'd3;
          acc_d    = {29'd0, byte_q[2:0]};
        end else if (!byte_q[2]) begin
          expect_d = 3'd4;
          acc_d    = {30'd0, byte_q[1:0]};
        end else begin
          expect_d = 3'd5;
          acc_d    = {30'd0, byte_q[1:0]};
        end
      end

      // A closed value becomes one unit, a surrogate pair or an error.
      v = acc_d;
      w = v[20:0] - SuppBase;
      if (close) begin
        if (v[31:16] == 16'd0) begin
          r.code_unit = v[15:0];
          r.kind      = KIND_UNIT;
          r.last      = 1'b0;
          set_d.item[n] = r;
          n = n + 2'd1;
        end else if ((v[31:21] == 11'd0) && !(v[20] && (v[19:16] != 4'd0))) begin
          r.code_unit = SurrHiBase + {6'd0, w[19:10]};
          r.kind      = KIND_UNIT;
          r.last      = 1'b0;
          set_d.item[n] = r;
          n = n + 2'd1;
          r.code_unit = SurrLoBase + {6'd0, w[9:0]};
          set_d.item[n] = r;
          n = n + 2'd1;
        end else begin
          err = 1'b1;
        end
        expect_d = '0;
        acc_d    = '0;
      end

      // Closing error or end beat.
      if (err) begin
        r.code_unit = '0;
        r.kind      = KIND_ERROR;
        r.last      = 1'b1;
        set_d.item[n] = r;
        n = n + 2'd1;
        expect_d = '0;
        acc_d    = '0;
        skip_d   = !eot_q;
      end else if (eot_q) begin
        r.code_unit = '0;
        r.kind      = KIND_END;
        r.last      = 1'b1;
        set_d.item[n] = r;
        n = n + 2'd1;
        expect_d = '0;
        acc_d    = '0;
      end
    end
    set_d.count = n;
  end

endmodule

@@ rtl/u8u16_emit.sv @@
// Result register that hands out the beats of one result set in order.
module u8u16_emit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   set_valid_i,
  output logic                   set_ready_o,
  input  u8u16_pkg::result_set_t set_i,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [15:0]            m_axis_tdata,   // code_unit
  output logic [1:0]             m_axis_tuser,   // kind
  output logic                   m_axis_tlast    // last
);
  import u8u16_pkg::*;

  result_t [MaxResults-1:0] slots_q;
  logic [1:0]               rem_q;
  logic [1:0]               idx_q;
  logic                     beat_out;
  logic                     load;
  result_t                  cur;

  assign beat_out    = m_axis_tvalid && m_axis_tready;
  assign set_ready_o = (rem_q == 2'd0) || ((rem_q == 2'd1) && m_axis_tready);
  assign load        = set_valid_i && set_ready_o;

  // Remaining-beat count and read pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else if (load) begin
      rem_q <= set_i.count;
      idx_q <= '0;
    end else if (beat_out) begin
      rem_q <= rem_q - 2'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      slots_q <= set_i.item;
    end
  end

  // Present the current beat.
  assign cur           = slots_q[idx_q];
  assign m_axis_tvalid = (rem_q != 2'd0);
  assign m_axis_tdata  = cur.code_unit;
  assign m_axis_tuser  = cur.kind;
  assign m_axis_tlast  = cur.last;

endmodule

@@ rtl/u8u16_checker.sv @@
// Port-level assertions for the UTF-8 to UTF-16 decoder, with its bind.
module u8u16_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import u8u16_pkg::*;

  // A stalled output beat holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // End and error beats close the run and carry no code unit.
  a_close_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_UNIT) |-> m_axis_tlast && (m_axis_tdata == 16'd0))
    else $error("end or error beat without last or with nonzero data");

  // Code unit beats never close the run.
  a_unit_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_UNIT) |-> !m_axis_tlast)
    else $error("code unit beat marked last");

  // The input side only stalls while a result beat is waiting.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending output beat");

  // Reset leaves the output stage empty.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the UTF-8 to UTF-16 decoder stream block.
module testbench;
  import u8u16_pkg::*;

  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned RandomBytes = 270;

  // Lead byte bases for sequences with one to five continuation bytes.
  localparam logic [7:0] Lead1Base = 8'hC0;
  localparam logic [7:0] Lead2Base = 8'hE0;
  localparam logic [7:0] Lead3Base = 8'hF0;
  localparam logic [7:0] Lead4Base = 8'hF8;
  localparam logic [7:0] Lead5Base = 8'hFC;
  localparam logic [7:0] ContBase  = 8'h80;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       eot;
  } text_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  text_beat_t  byte_q[$];
  logic [7:0]  text_buf[$];
  result_t     unit_q[$];
  text_beat_t  next_beat;
  result_t     want;

  // Decoder state as predicted by the testbench.
  logic [2:0]  cont_left = 3'd0;
  logic [31:0] code_acc = 32'd0;
  logic        skip_to_end = 1'b0;

  int unsigned bytes_taken = 0;
  int unsigned total_bytes = 0;
  int unsigned err_cnt = 0;
  int unsigned quiet_cnt = 0;
  logic        stuck = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned stall_phase = 0;

  utf8_to_utf16_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // text_byte
    .s_axis_tlast  (s_axis_tlast),   // end_of_text
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // code_unit
    .m_axis_tuser  (m_axis_tuser),   // kind
    .m_axis_tlast  (m_axis_tlast)    // last
  );

  // Free-running clock with a period of 8.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void push_unit(input logic [15:0] cu, input kind_e k, input logic l);
    result_t r;
    r.code_unit = cu;
    r.kind      = k;
    r.last      = l;
    unit_q.push_back(r);
  endfunction

  // Predicts the result beats of one accepted text byte and updates the state.
  function automatic void decode_byte(input logic [7:0] b, input logic eot);
    logic        err;
    logic        close;
    logic [31:0] v;
    err   = 1'b0;
    close = 1'b0;
    if (skip_to_end) begin
      if (eot) skip_to_end = 1'b0;
      return;
    end
    if (cont_left != 3'd0) begin
      if (b[7:6] == 2'b10) begin
        code_acc  = {code_acc[25:0], b[5:0]};
        cont_left = cont_left - 3'd1;
        close     = (cont_left == 3'd0) || eot;
      end else begin
        // A byte that breaks the sequence closes it and is dropped.
        close = 1'b1;
      end
    end else if (b < ContBase) begin
      push_unit({8'h00, b}, KIND_UNIT, 1'b0);
    end else if (b < Lead1Base) begin
      err = 1'b1;
    end else begin
      if (b < Lead2Base) begin
        cont_left = 3'd1;
        code_acc  = {24'd0, b - Lead1Base};
      end else if (b < Lead3Base) begin
        cont_left = 3'd2;
        code_acc  = {24'd0, b - Lead2Base};
      end else if (b < Lead4Base) begin
        cont_left = 3'd3;
        code_acc  = {24'd0, b - Lead3Base};
      end else if (b < Lead5Base) begin
        cont_left = 3'd4;
        code_acc  = {24'd0, b - Lead4Base};
      end else begin
        cont_left = 3'd5;
        code_acc  = {24'd0, b - Lead5Base};
      end
      close = eot;
    end

    // A closed value becomes one unit, a surrogate pair, or an error.
    if (close) begin
      if (code_acc < {11'd0, SuppBase}) begin
        push_unit(code_acc[15:0], KIND_UNIT, 1'b0);
      end else begin
        v = code_acc - {11'd0, SuppBase};
        if (v >= 32'h0010_0000) begin
          err = 1'b1;
        end else begin
          push_unit(SurrHiBase + {6'd0, v[19:10]}, KIND_UNIT, 1'b0);
          push_unit(SurrLoBase + {6'd0, v[9:0]}, KIND_UNIT, 1'b0);
        end
      end
      cont_left = 3'd0;
      code_acc  = 32'd0;
    end

    if (err) begin
      push_unit(16'h0000, KIND_ERROR, 1'b1);
      cont_left = 3'd0;
      code_acc  = 32'd0;
      if (!eot) skip_to_end = 1'b1;
    end else if (eot) begin
      cont_left = 3'd0;
      code_acc  = 32'd0;
      push_unit(16'h0000, KIND_END, 1'b1);
    end
  endfunction

  // Appends one encoded character to the text buffer, keeping only some of
  // its continuation bytes when the sequence is to be cut short.
  task automatic add_char(input logic [31:0] cp, input int n, input int keep);
    logic [7:0] lead;
    case (n)
      0: lead = {1'b0, cp[6:0]};
      1: lead = Lead1Base | {3'd0, cp[10:6]};
      2: lead = Lead2Base | {4'd0, cp[15:12]};
      3: lead = Lead3Base | {5'd0, cp[20:18]};
      4: lead = Lead4Base | {6'd0, cp[25:24]};
      default: lead = Lead5Base | {6'd0, cp[31:30]};
    endcase
    text_buf.push_back(lead);
    for (int i = 0; i < keep; i++) begin
      text_buf.push_back(ContBase | {2'b00, 6'((cp >> (6 * (n - 1 - i))) & 32'h3F)});
    end
  endtask

  // Moves the buffered text into the byte queue, flagging its final byte.
  task automatic flush_text();
    text_beat_t t;
    for (int i = 0; i < text_buf.size(); i++) begin
      t.text_byte = text_buf[i];
      t.eot       = (i == text_buf.size() - 1);
      byte_q.push_back(t);
    end
    text_buf.delete();
  endtask

  // Builds one random text, mostly well-formed with some broken sequences.
  task automatic add_random_text();
    int          nchars;
    int          cls;
    int          n;
    logic [31:0] cp;
    nchars = $urandom_range(1, 8);
    for (int c = 0; c < nchars; c++) begin
      cls = $urandom_range(0, 99);
      cp  = $urandom;
      if (cls < 40) begin
        add_char(cp, 0, 0);
      end else if (cls < 55) begin
        add_char(cp, 1, 1);
      end else if (cls < 70) begin
        add_char(cp, 2, 2);
      end else if (cls < 85) begin
        if ($urandom_range(0, 7) != 0) cp = $urandom_range(32'h10000, 32'h10FFFF);
        add_char(cp, 3, 3);
      end else if (cls < 88) begin
        add_char(cp, 4, 4);
      end else if (cls < 90) begin
        add_char(cp, 5, 5);
      end else if (cls < 95) begin
        n = $urandom_range(1, 5);
        add_char(cp, n, $urandom_range(0, n - 1));
      end else begin
        text_buf.push_back(8'($urandom_range(0, 255)));
      end
    end
    flush_text();
  endtask

  // Driver: sends queued text bytes in bursts separated by random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, s_axis_tlast);
        bytes_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          next_beat = byte_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_beat.text_byte;
          s_axis_tlast  <= next_beat.eot;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat and stalls the output on its own pattern.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (unit_q.size() == 0) begin
          $error("unexpected beat: code_unit %h kind %0d last %0b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          err_cnt++;
        end else begin
          want = unit_q.pop_front();
          if (m_axis_tdata !== want.code_unit) begin
            $error("code_unit: expected %h, got %h", want.code_unit, m_axis_tdata);
            err_cnt++;
          end
          if (m_axis_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
            err_cnt++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
            err_cnt++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 80);
      end else begin
        mode_left--;
      end
      stall_phase++;
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= (stall_phase % 4 == 0);
        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Watchdog on cycles in which neither side moves a beat.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt + 1 >= QuietLimit) stuck <= 1'b1;
    end
  end

  // Stimulus, reset and the end of the run.
  initial begin
    // ASCII at the field extremes, an end beat after the zero, then U+00BF.
    text_buf = '{8'h00};
    flush_text();
    text_buf = '{8'h7F, 8'hC2, 8'hBF};
    flush_text();
    // Three-byte character, then a surrogate pair closed by the final byte.
    text_buf = '{8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
    flush_text();
    // Value too large on the final byte.
    text_buf = '{8'hF4, 8'h90, 8'h80, 8'h80};
    flush_text();
    // Stray continuation byte; the rest of the text is skipped.
    text_buf = '{8'h80, 8'h41, 8'hFF};
    flush_text();
    // Early close on a non-continuation byte, then a lead byte at the end.
    text_buf = '{8'hE0, 8'h41, 8'hC5};
    flush_text();
    // Value too large in mid-text, followed by skipping.
    text_buf = '{8'hF8, 8'h88, 8'h80, 8'h80, 8'h80, 8'h41};
    flush_text();

    while (byte_q.size() < 27 + RandomBytes) add_random_text();
    total_bytes = byte_q.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_taken != total_bytes && !stuck) @(negedge clk_i);
    while (unit_q.size() != 0 && !stuck) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (stuck || err_cnt != 0 || unit_q.size() != 0) begin
      if (unit_q.size() != 0) $error("%0d result beats never arrived", unit_q.size());
      $display("== FAIL ==");
    end else begin
      $display("== PASS ==");
    end
    $finish;
  end

endmodule

@@ utf8_to_utf16_decoder.f @@
rtl/u8u16_pkg.sv
rtl/u8u16_decode.sv
rtl/u8u16_emit.sv
rtl/utf8_to_utf16_decoder.sv
rtl/u8u16_checker.sv
tb/testbench.sv
